// ===== src/roks_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roks_pkg
// Shared types and constants for the recency ordered key store.
// ----------------------------------------------------------------------------
package roks_pkg;

   localparam int DEPTH      = 16;
   localparam int KEY_WIDTH  = 32;
   localparam int TYPE_WIDTH = 2;
   localparam int CAP_WIDTH  = 5;
   localparam int CNT_WIDTH  = 5;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(16);

   typedef enum logic [TYPE_WIDTH-1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_USE    = 2'd2,
      REQ_FIND   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PREV,
      CELL_NEXT,
      CELL_LOAD
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [TYPE_WIDTH-1:0] req_type;
      logic [31:0]           key;
   } req_word_type;

   typedef struct packed {
      logic                 result_flag;
      logic [CNT_WIDTH-1:0] entry_count;
   } rsp_word_type;

endpackage

// ===== src/recency_ordered_key_store_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recency_ordered_key_store_unit
// Bounded key store kept newest-first in a chain of slots.
// ----------------------------------------------------------------------------
// Each request word is handled in an accept cycle and a commit state. In the
// accept cycle every slot compares its key against the request and registers
// a match bit; in the commit state the front-most match is picked, every slot
// loads from itself, its front neighbor or its rear neighbor, and the response
// word is registered. The next request is taken in the cycle after that, even
// while the response still waits on rsp_ready; a stalled response holds the
// commit state until it leaves. Capacity may be written only while idle.
// ----------------------------------------------------------------------------
module recency_ordered_key_store_unit
   import roks_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_word_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_word_type         rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CAP_WIDTH-1:0] csr_wr_data
);

   logic [DEPTH-1:0]     match;
   logic [DEPTH-1:0]     live;
   logic                 capture;
   logic [KEY_WIDTH-1:0] load_key;
   logic [KEY_WIDTH-1:0] keys [DEPTH];
   cell_op_type          ops [DEPTH];

   roks_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .match       (match),
      .capture     (capture),
      .live        (live),
      .load_key    (load_key),
      .ops         (ops)
   );

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [KEY_WIDTH-1:0] prev_key;
         logic [KEY_WIDTH-1:0] next_key;

         if (gi == 0) begin : g_front
            assign prev_key = load_key;
         end else begin : g_mid_prev
            assign prev_key = keys[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_rear
            assign next_key = keys[gi];
         end else begin : g_mid_next
            assign next_key = keys[gi+1];
         end

         roks_cell u_cell (
            .clock     (clock),
            .capture   (capture),
            .live      (live[gi]),
            .cmp_key   (req_data.key[KEY_WIDTH-1:0]),
            .op        (ops[gi]),
            .prev_key  (prev_key),
            .next_key  (next_key),
            .load_key  (load_key),
            .key_out   (keys[gi]),
            .match_out (match[gi])
         );
      end
   endgenerate

endmodule

// ===== src/roks_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roks_cell
// One slot of the key chain: holds a key, compares it, shifts with neighbors.
// ----------------------------------------------------------------------------
module roks_cell
   import roks_pkg::*;
(
   input  logic                 clock,
   input  logic                 capture,
   input  logic                 live,
   input  logic [KEY_WIDTH-1:0] cmp_key,
   input  cell_op_type          op,
   input  logic [KEY_WIDTH-1:0] prev_key,
   input  logic [KEY_WIDTH-1:0] next_key,
   input  logic [KEY_WIDTH-1:0] load_key,
   output logic [KEY_WIDTH-1:0] key_out,
   output logic                 match_out
);

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 match_ff, match_in;

   always_comb begin
      case (op)
         CELL_PREV: key_in = prev_key;
         CELL_NEXT: key_in = next_key;
         CELL_LOAD: key_in = load_key;
         default:   key_in = key_ff;
      endcase
      match_in = capture ? (live && (key_ff == cmp_key)) : match_ff;
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      match_ff <= match_in;
   end

   assign key_out   = key_ff;
   assign match_out = match_ff;

endmodule

// ===== src/roks_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roks_ctrl
// Sequencer: capacity register, occupancy, per-cell shift control, response.
// ----------------------------------------------------------------------------
module roks_ctrl
   import roks_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_word_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_word_type         rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CAP_WIDTH-1:0] csr_wr_data,
   input  logic [DEPTH-1:0]     match,
   output logic                 capture,
   output logic [DEPTH-1:0]     live,
   output logic [KEY_WIDTH-1:0] load_key,
   output cell_op_type          ops [DEPTH]
);

   state_type            state_ff, state_in;
   logic [CAP_WIDTH-1:0] cap_ff, cap_in;
   logic [CNT_WIDTH-1:0] occ_ff, occ_in;
   req_kind_type         kind_ff, kind_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_ff, rsp_in;

   logic                 go;
   logic [CAP_WIDTH-1:0] eff_cap;
   logic [DEPTH-1:0]     first;
   logic [DEPTH-1:0]     below;
   logic                 found;
   logic                 full;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_COMMIT;
         ST_COMMIT: if (go) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      go        = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_COMMIT: go = !rsp_valid_ff || rsp_ready;
         default:   req_ready = 1'b0;
      endcase
   end

   assign capture = req_valid && req_ready;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_live
         assign live[gi] = CNT_WIDTH'(gi) < occ_ff;
      end
   endgenerate

   assign first = match & (~match + DEPTH'(1));
   assign below = first - DEPTH'(1);
   assign found = |match;

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CAP_WIDTH'(1);
      end else if (cap_ff > CAP_WIDTH'(DEPTH)) begin
         eff_cap = CAP_WIDTH'(DEPTH);
      end else begin
         eff_cap = cap_ff;
      end
      full = occ_ff >= CNT_WIDTH'(eff_cap);
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ops[i] = CELL_HOLD;
         if (go) begin
            case (kind_ff)
               REQ_INSERT: ops[i] = (i == 0) ? CELL_LOAD : CELL_PREV;
               REQ_REMOVE: begin
                  if (found && !below[i] && (i != DEPTH - 1)) ops[i] = CELL_NEXT;
               end
               REQ_USE: begin
                  if (found) begin
                     if (i == 0) ops[i] = CELL_LOAD;
                     else if (below[i] || first[i]) ops[i] = CELL_PREV;
                  end
               end
               default: ops[i] = CELL_HOLD;
            endcase
         end
      end
   end

   always_comb begin
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      kind_in      = capture ? req_kind_type'(req_data.req_type) : kind_ff;
      key_in       = capture ? req_data.key[KEY_WIDTH-1:0] : key_ff;
      occ_in       = occ_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (go) begin
         rsp_valid_in = 1'b1;
         case (kind_ff)
            REQ_INSERT: begin
               rsp_in.result_flag = full;
               if (!full) occ_in = occ_ff + CNT_WIDTH'(1);
            end
            REQ_REMOVE: begin
               rsp_in.result_flag = found;
               if (found) occ_in = occ_ff - CNT_WIDTH'(1);
            end
            default: rsp_in.result_flag = found;
         endcase
         rsp_in.entry_count = occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      key_ff  <= key_in;
      rsp_ff  <= rsp_in;
   end

   assign load_key  = key_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/roks_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roks_checker
// Port-level checks for the recency ordered key store.
// ----------------------------------------------------------------------------
module roks_checker
   import roks_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rsp_word_type         rsp_data,
   input logic                 csr_wr_en
);

   // response word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= CNT_WIDTH'(DEPTH))
      else $error("entry count beyond depth");

   // one request word in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while one is in flight");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a work cycle");

   // capacity is written only with nothing in flight
   a_cap_idle: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |-> req_ready && !rsp_valid)
      else $error("capacity written while busy");

endmodule

bind recency_ordered_key_store_unit roks_checker u_roks_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_data    (rsp_data),
   .csr_wr_en   (csr_wr_en)
);

// ===== tb/sv/tb_recency_ordered_key_store_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_recency_ordered_key_store_unit
// Self-checking bench for the recency ordered key store. A newest-first key
// list in the bench tracks every accepted request word and predicts each
// response word. Directed requests cover the empty store, duplicate keys and
// capacity corners; random phases then run under many capacity settings,
// with random gaps on both channels and one long response stall.
// ----------------------------------------------------------------------------
module tb_recency_ordered_key_store_unit;
   import roks_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_WORDS  = 150;
   localparam int POOL_MAX     = 12;
   localparam int STALL_CYCLES = 300;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_word_type         req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_word_type         rsp_data;
   logic                 csr_wr_en;
   logic [CAP_WIDTH-1:0] csr_wr_data;

   logic [KEY_WIDTH-1:0] model_slots [DEPTH];
   int                   model_count;
   logic [CAP_WIDTH-1:0] model_capacity;
   rsp_word_type         pending_rsps [$];

   logic [31:0]          key_pool [POOL_MAX];
   int                   pool_size;
   bit                   tx_burst;
   bit                   rx_burst;
   int                   hold_off_cycles;
   int                   rx_stall_left;
   int                   mismatches;
   int                   cycle_count;

   recency_ordered_key_store_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_recency_ordered_key_store_unit NOT OK");
         $finish;
      end
   end

   // newest-first list: updates the bench copy and returns the response word
   function automatic rsp_word_type predict_lru_response(input req_word_type w);
      rsp_word_type         r;
      int                   eff_cap;
      int                   pos;
      logic [KEY_WIDTH-1:0] k;
      k       = w.key[KEY_WIDTH-1:0];
      eff_cap = (model_capacity == 0) ? 1 :
                (int'(model_capacity) > DEPTH) ? DEPTH : int'(model_capacity);
      r.result_flag = 1'b0;
      if (req_kind_type'(w.req_type) == REQ_INSERT) begin
         if (model_count >= eff_cap) begin
            model_count--;
            r.result_flag = 1'b1;
         end
         for (int i = model_count; i > 0; i--)
            model_slots[i] = model_slots[i-1];
         model_slots[0] = k;
         model_count++;
      end else begin
         pos = model_count;
         for (int i = 0; i < model_count; i++)
            if (pos == model_count && model_slots[i] == k)
               pos = i;
         if (pos < model_count) begin
            r.result_flag = 1'b1;
            if (req_kind_type'(w.req_type) == REQ_REMOVE) begin
               for (int i = pos; i < model_count - 1; i++)
                  model_slots[i] = model_slots[i+1];
               model_count--;
            end else if (req_kind_type'(w.req_type) == REQ_USE) begin
               for (int i = pos; i > 0; i--)
                  model_slots[i] = model_slots[i-1];
               model_slots[0] = k;
            end
         end
      end
      r.entry_count = CNT_WIDTH'(model_count);
      return r;
   endfunction

   function automatic int pick_gap(input bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // response side: random stalls plus the long hold-off when requested
   initial begin
      rsp_ready     = 1'b0;
      rx_stall_left = 0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else if (rx_stall_left > 0) begin
            rsp_ready <= 1'b0;
            rx_stall_left--;
         end else begin
            rsp_ready     <= 1'b1;
            rx_stall_left = pick_gap(rx_burst);
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            $error("response word with none expected: flag %0d count %0d",
                   rsp_data.result_flag, rsp_data.entry_count);
            mismatches++;
         end else begin
            exp_word = pending_rsps.pop_front();
            if (rsp_data.result_flag !== exp_word.result_flag) begin
               $error("result_flag: expected %0d, got %0d",
                      exp_word.result_flag, rsp_data.result_flag);
               mismatches++;
            end
            if (rsp_data.entry_count !== exp_word.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      exp_word.entry_count, rsp_data.entry_count);
               mismatches++;
            end
         end
      end
   end

   // called at a falling edge; returns at a falling edge
   task automatic send_word(input req_kind_type kind, input logic [31:0] key);
      req_word_type w;
      int           gap;
      w.req_type = kind;
      w.key      = key;
      req_data  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_rsps.push_back(predict_lru_response(w));
      @(negedge clock);
      gap = pick_gap(tx_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_WIDTH-1:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en      <= 1'b0;
      model_capacity = value;
   endtask

   task automatic refill_pool();
      pool_size = $urandom_range(3, POOL_MAX);
      for (int i = 0; i < POOL_MAX; i++)
         key_pool[i] = $urandom();
   endtask

   task automatic send_random_word();
      int           r;
      req_kind_type kind;
      logic [31:0]  key;
      r = $urandom_range(0, 99);
      if (r < 35)
         kind = REQ_INSERT;
      else if (r < 55)
         kind = REQ_REMOVE;
      else if (r < 75)
         kind = REQ_USE;
      else
         kind = REQ_FIND;
      if ($urandom_range(0, 9) == 0)
         key = $urandom();
      else
         key = key_pool[$urandom_range(0, pool_size - 1)];
      send_word(kind, key);
   endtask

   task automatic test_empty_store();
      send_word(REQ_FIND, 32'h0000_0000);
      send_word(REQ_REMOVE, 32'hFFFF_FFFF);
      send_word(REQ_USE, 32'h5A5A_5A5A);
      wait_drained();
   endtask

   task automatic test_duplicates_and_order();
      send_word(REQ_INSERT, 32'h0000_0000);
      send_word(REQ_INSERT, 32'hFFFF_FFFF);
      send_word(REQ_INSERT, 32'h0000_0000);
      send_word(REQ_USE, 32'hFFFF_FFFF);
      send_word(REQ_FIND, 32'h0000_0000);
      send_word(REQ_REMOVE, 32'h0000_0000);
      send_word(REQ_FIND, 32'h1234_5678);
      wait_drained();
   endtask

   task automatic test_capacity_limits();
      // zero means one; count stays above it until removes bring it down
      set_capacity(CAP_WIDTH'(0));
      send_word(REQ_INSERT, 32'hA5A5_0001);
      send_word(REQ_REMOVE, 32'hA5A5_0001);
      send_word(REQ_INSERT, 32'hA5A5_0002);
      send_word(REQ_FIND, 32'hA5A5_0002);
      wait_drained();
      set_capacity(CAP_WIDTH'(31));
      send_word(REQ_INSERT, 32'h8000_0000);
      send_word(REQ_INSERT, 32'h7FFF_FFFF);
      wait_drained();
   endtask

   task automatic test_backpressure();
      refill_pool();
      tx_burst        = 1'b1;
      hold_off_cycles = STALL_CYCLES;
      repeat (20) send_random_word();
      tx_burst = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_traffic();
      logic [CAP_WIDTH-1:0] caps [12];
      caps = '{5'd31, 5'd3, 5'd16, 5'd0, 5'd7, 5'd20, 5'd1, 5'd12, 5'd2, 5'd16,
               5'd0, 5'd0};
      caps[10] = $urandom_range(0, 31);
      caps[11] = $urandom_range(0, 31);
      for (int p = 0; p < 12; p++) begin
         set_capacity(caps[p]);
         refill_pool();
         tx_burst = (p % 4 == 1);
         rx_burst = (p % 4 == 2);
         repeat (PHASE_WORDS) send_random_word();
         wait_drained();
      end
      tx_burst = 1'b0;
      rx_burst = 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      model_count     = 0;
      model_capacity  = CAP_RESET;
      tx_burst        = 1'b0;
      rx_burst        = 1'b0;
      hold_off_cycles = 0;
      mismatches      = 0;
      cycle_count     = 0;
      pool_size       = 1;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_store();
      test_duplicates_and_order();
      test_capacity_limits();
      test_backpressure();
      test_random_traffic();

      repeat (20) @(negedge clock);
      if (mismatches == 0 && pending_rsps.size() == 0)
         $display("tb_recency_ordered_key_store_unit OK");
      else
         $display("tb_recency_ordered_key_store_unit NOT OK");
      $finish;
   end

endmodule

// ===== recency_ordered_key_store_unit.f =====
src/roks_pkg.sv
src/roks_cell.sv
src/roks_ctrl.sv
src/recency_ordered_key_store_unit.sv
src/roks_checker.sv
tb/sv/tb_recency_ordered_key_store_unit.sv
